// ===== sv/sync_frame_parser_with_passthrough_defines.svh =====
// Assertion macros for the sync frame parser.
// Included by the top level; relies on clk_i and rst_ni being in scope.
`ifndef SYNC_FRAME_PARSER_WITH_PASSTHROUGH_DEFINES_SVH
`define SYNC_FRAME_PARSER_WITH_PASSTHROUGH_DEFINES_SVH

// Same-cycle implication, checked on every rising edge out of reset.
`define SFP_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication.
`define SFP_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== sv/sfp_pkg.sv =====
// Shared types and constants for the sync frame parser.
// No dependencies; imported by every module of the block.
package sfp_pkg;

  localparam int unsigned SFP_MAX_FRAME = 260;
  localparam int unsigned COUNT_W       = 9;
  localparam int unsigned CFG_IDX_W     = 8;
  localparam int unsigned CFG_DATA_W    = 8;
  localparam int unsigned OUT_DATA_W    = 80;

  localparam logic [7:0] SYNC_A   = 8'h55;
  localparam logic [7:0] SYNC_B   = 8'hAA;
  localparam logic [7:0] PASS_KEY = 8'h48;

  localparam logic [7:0] CLASS1_LO = 8'h40;
  localparam logic [7:0] CLASS1_HI = 8'h7F;
  localparam logic [7:0] CLASS2_LO = 8'h20;
  localparam logic [7:0] CLASS2_HI = 8'h3E;

  // Configuration register indexes
  localparam logic [CFG_IDX_W-1:0] REG_STREAM_ON  = 8'd0;
  localparam logic [CFG_IDX_W-1:0] REG_STREAM_OFF = 8'd1;
  localparam logic [CFG_IDX_W-1:0] REG_SET_BAUD   = 8'd2;
  localparam logic [CFG_IDX_W-1:0] REG_BAUD_HOOK  = 8'd3;

  // Frame status codes
  localparam logic [1:0] STAT_NONE     = 2'd0;
  localparam logic [1:0] STAT_OK       = 2'd1;
  localparam logic [1:0] STAT_CSUM_ERR = 2'd2;
  localparam logic [1:0] STAT_OVERFLOW = 2'd3;

  // Handler classes
  localparam logic [1:0] HCLASS_NONE = 2'd0;
  localparam logic [1:0] HCLASS_HIGH = 2'd1;
  localparam logic [1:0] HCLASS_LOW  = 2'd2;

  typedef struct packed {
    logic [7:0] cmd_stream_on;
    logic [7:0] cmd_stream_off;
    logic [7:0] cmd_set_baud;
    logic       baud_hook_enabled;
  } cfg_t;

  typedef struct packed {
    logic        route_passthrough;
    logic        claimed;
    logic        payload_valid;
    logic [7:0]  payload_byte;
    logic [7:0]  payload_index;
    logic [1:0]  frame_status;
    logic [7:0]  frame_cmd;
    logic [7:0]  frame_length;
    logic [1:0]  handler_class;
    logic [7:0]  stream_control;
    logic        baud_valid;
    logic [31:0] baud_value;
  } result_t;

endpackage

// ===== sv/sync_frame_parser_with_passthrough.sv =====
// Sync frame parser with passthrough routing: byte register, parser and result register.
// Depends on sfp_pkg, sfp_cfg_regs, sfp_parser and the defines header.
//
// Usage:
//   s_axis carries one received UART byte per transfer (tdata[7:0] = rx_byte).
//   m_axis returns exactly one result per input byte, in order: tuser flags a
//   byte for the passthrough channel, tdata carries the frame decode.
//   The cfg channel writes one configuration register per transfer
//   (0 stream-on cmd, 1 stream-off cmd, 2 set-baud cmd, 3 baud hook enable);
//   cfg_ready_o is always high. Write it only while the stream is idle.
// Timing: an accepted byte waits in the byte register, which feeds the parser;
//   its decode is registered in the result register and presented from there.
// Throughput: one byte per cycle while m_axis is not held off; the parser state
//   is a running checksum and a byte counter, so every byte finishes in a single
//   pass through the decode.
// Reset: parser returns to idle, counters, checksum, baud word and stream value
//   clear, all configuration registers read zero; no item is held.
// Stall: while m_axis is held off the result register holds, and one more byte
//   is taken into the byte register; s_axis_tready_o then drops until the result
//   is taken.
module sync_frame_parser_with_passthrough #(
  parameter int unsigned MAX_FRAME = sfp_pkg::SFP_MAX_FRAME
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  // input byte stream
  input  logic                           s_axis_tvalid_i,
  output logic                           s_axis_tready_o,
  input  logic [7:0]                     s_axis_tdata_i,   // [7:0] rx_byte
  // result stream
  output logic                           m_axis_tvalid_o,
  input  logic                           m_axis_tready_i,
  // [0] claimed, [1] payload_valid, [9:2] payload_byte, [17:10] payload_index,
  // [19:18] frame_status, [27:20] frame_cmd, [35:28] frame_length,
  // [37:36] handler_class, [45:38] stream_control, [46] baud_valid,
  // [78:47] baud_value, [79] zero
  output logic [sfp_pkg::OUT_DATA_W-1:0] m_axis_tdata_o,
  output logic                           m_axis_tuser_o,   // [0] route_passthrough
  // configuration writes
  input  logic                           cfg_valid_i,
  output logic                           cfg_ready_o,
  input  logic [sfp_pkg::CFG_IDX_W-1:0]  cfg_index_i,
  input  logic [sfp_pkg::CFG_DATA_W-1:0] cfg_data_i
);
  import sfp_pkg::*;

  `include "sync_frame_parser_with_passthrough_defines.svh"

  cfg_t       cfg;
  result_t    parse_res;
  result_t    out_res_q;
  logic       out_valid_q;
  logic       byte_valid_q;
  logic [7:0] byte_q;
  logic       out_free;
  logic       fire;
  logic       in_xfer;

  // Result register can take a new entry when empty or being drained.
  assign out_free        = !out_valid_q || m_axis_tready_i;
  assign fire            = byte_valid_q && out_free;
  assign s_axis_tready_o = !byte_valid_q || out_free;
  assign in_xfer         = s_axis_tvalid_i && s_axis_tready_o;
  assign cfg_ready_o     = 1'b1;

  sfp_cfg_regs u_cfg (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .wr_en_i    (cfg_valid_i),
    .wr_index_i (cfg_index_i),
    .wr_data_i  (cfg_data_i),
    .cfg_o      (cfg)
  );

  sfp_parser #(
    .MAX_FRAME (MAX_FRAME)
  ) u_parser (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .fire_i    (fire),
    .rx_byte_i (byte_q),
    .cfg_i     (cfg),
    .res_o     (parse_res)
  );

  // Byte register: load on every input transfer, empty once parsed.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      byte_valid_q <= 1'b0;
    end else if (in_xfer) begin
      byte_valid_q <= 1'b1;
    end else if (fire) begin
      byte_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_xfer) begin
      byte_q <= s_axis_tdata_i;
    end
  end

  // Result register: hold while the receiver stalls.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (out_free) begin
      out_valid_q <= byte_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (fire) begin
      out_res_q <= parse_res;
    end
  end

  assign m_axis_tvalid_o = out_valid_q;
  assign m_axis_tuser_o  = out_res_q.route_passthrough;
  assign m_axis_tdata_o  = {1'b0,
                            out_res_q.baud_value,
                            out_res_q.baud_valid,
                            out_res_q.stream_control,
                            out_res_q.handler_class,
                            out_res_q.frame_length,
                            out_res_q.frame_cmd,
                            out_res_q.frame_status,
                            out_res_q.payload_index,
                            out_res_q.payload_byte,
                            out_res_q.payload_valid,
                            out_res_q.claimed};

  // A stalled result with a byte already waiting must close the input side.
  `SFP_ASSERT_NOW(a_full_blocks_input, byte_valid_q && out_valid_q && !m_axis_tready_i, !s_axis_tready_o, "input open while both registers are full")
  // A payload byte never coincides with a frame end.
  `SFP_ASSERT_NOW(a_payload_no_status, out_valid_q && out_res_q.payload_valid, out_res_q.frame_status == STAT_NONE, "payload byte reported with a frame status")
  // A handler class is only given to a good frame.
  `SFP_ASSERT_NOW(a_class_needs_ok, out_valid_q && out_res_q.handler_class != HCLASS_NONE, out_res_q.frame_status == STAT_OK, "handler class on a frame that is not ok")
  // A parsed byte always lands in the result register.
  `SFP_ASSERT_NEXT(a_fire_lands, fire, out_valid_q, "parsed byte lost before the result register")

endmodule

// ===== sv/sfp_cfg_regs.sv =====
// Configuration register file for the sync frame parser.
// Depends on sfp_pkg.
module sfp_cfg_regs (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          wr_en_i,
  input  logic [sfp_pkg::CFG_IDX_W-1:0]  wr_index_i,
  input  logic [sfp_pkg::CFG_DATA_W-1:0] wr_data_i,
  output sfp_pkg::cfg_t                 cfg_o
);
  import sfp_pkg::*;

  cfg_t cfg_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q <= '0;
    end else if (wr_en_i) begin
      case (wr_index_i)
        REG_STREAM_ON:  cfg_q.cmd_stream_on     <= wr_data_i;
        REG_STREAM_OFF: cfg_q.cmd_stream_off    <= wr_data_i;
        REG_SET_BAUD:   cfg_q.cmd_set_baud      <= wr_data_i;
        REG_BAUD_HOOK:  cfg_q.baud_hook_enabled <= wr_data_i[0];
        default: ; // ignore writes beyond the register list
      endcase
    end
  end

  assign cfg_o = cfg_q;

endmodule

// ===== sv/sfp_parser.sv =====
// Frame parser state and per-byte decode for the sync frame parser.
// Depends on sfp_pkg; state advances on each fire_i.
module sfp_parser #(
  parameter int unsigned MAX_FRAME = sfp_pkg::SFP_MAX_FRAME
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             fire_i,
  input  logic [7:0]       rx_byte_i,
  input  sfp_pkg::cfg_t    cfg_i,
  output sfp_pkg::result_t res_o
);
  import sfp_pkg::*;

  localparam logic [1:0] MODE_IDLE = 2'd0;
  localparam logic [1:0] MODE_SYNC = 2'd1;
  localparam logic [1:0] MODE_BODY = 2'd2;
  localparam logic [1:0] MODE_PASS = 2'd3;

  localparam logic [COUNT_W-1:0] MAX_CNT = COUNT_W'(MAX_FRAME);

  logic [1:0]         mode_q, mode_d;
  logic [COUNT_W-1:0] count_q, count_d;
  logic [7:0]         sum_q, sum_d;
  logic [7:0]         len_q, len_d;
  logic [7:0]         cmd_q, cmd_d;
  logic [31:0]        baud_q, baud_d;
  logic [7:0]         stream_q, stream_d;

  logic [COUNT_W-1:0] idx;
  logic [1:0]         status;
  logic [1:0]         hclass;
  result_t            res;

  always_comb begin
    mode_d   = mode_q;
    count_d  = count_q;
    sum_d    = sum_q;
    len_d    = len_q;
    cmd_d    = cmd_q;
    baud_d   = baud_q;
    stream_d = stream_q;
    res      = '0;
    status   = STAT_NONE;
    hclass   = HCLASS_NONE;
    idx      = count_q - COUNT_W'(5);

    case (mode_q)
      MODE_PASS: begin
        if (rx_byte_i == SYNC_A) begin
          mode_d  = MODE_SYNC;
          count_d = COUNT_W'(1);
          sum_d   = '0;
          baud_d  = '0;
        end else begin
          res.route_passthrough = 1'b1;
        end
      end
      MODE_IDLE: begin
        if (rx_byte_i == SYNC_A) begin
          mode_d  = MODE_SYNC;
          count_d = COUNT_W'(1);
          sum_d   = '0;
          baud_d  = '0;
        end else if (rx_byte_i == PASS_KEY) begin
          mode_d = MODE_PASS;
          res.route_passthrough = 1'b1;
        end
      end
      MODE_SYNC: begin
        if (rx_byte_i == SYNC_B) begin
          mode_d  = MODE_BODY;
          count_d = COUNT_W'(2);
        end else if (rx_byte_i == SYNC_A) begin
          count_d = COUNT_W'(1);
        end else begin
          mode_d  = MODE_IDLE;
          count_d = '0;
        end
      end
      default: begin
        if (count_q >= MAX_CNT) begin
          // frame longer than the buffer: drop the byte
          status  = STAT_OVERFLOW;
          mode_d  = MODE_IDLE;
          count_d = '0;
        end else begin
          count_d = count_q + COUNT_W'(1);
          if (count_q <= COUNT_W'(4)) begin
            if (count_q == COUNT_W'(3)) begin
              len_d = rx_byte_i;
            end else if (count_q == COUNT_W'(4)) begin
              cmd_d = rx_byte_i;
            end
            sum_d = sum_q + rx_byte_i;
          end else if (count_q < (COUNT_W'(5) + COUNT_W'(len_q))) begin
            res.payload_valid = 1'b1;
            res.payload_byte  = rx_byte_i;
            res.payload_index = idx[7:0];
            if (idx < COUNT_W'(4)) begin
              baud_d = baud_q | (32'(rx_byte_i) << {idx[1:0], 3'b000});
            end
            sum_d = sum_q + rx_byte_i;
          end else begin
            // checksum byte closes the frame
            mode_d  = MODE_IDLE;
            count_d = '0;
            if (sum_q != rx_byte_i) begin
              status = STAT_CSUM_ERR;
            end else begin
              status = STAT_OK;
              if (cmd_q == cfg_i.cmd_stream_on) begin
                stream_d = (len_q != 8'd0) ? baud_q[7:0] : 8'd1;
              end else if (cmd_q == cfg_i.cmd_stream_off) begin
                stream_d = '0;
              end else if (cmd_q == cfg_i.cmd_set_baud && len_q >= 8'd4 &&
                           cfg_i.baud_hook_enabled) begin
                res.baud_valid = 1'b1;
                res.baud_value = baud_q;
              end
              if (cmd_q >= CLASS1_LO && cmd_q <= CLASS1_HI) begin
                hclass = HCLASS_HIGH;
              end else if (cmd_q >= CLASS2_LO && cmd_q <= CLASS2_HI) begin
                hclass = HCLASS_LOW;
              end
            end
          end
        end
      end
    endcase

    res.frame_status   = status;
    res.handler_class  = hclass;
    res.claimed        = (hclass != HCLASS_NONE) || (mode_d == MODE_SYNC) ||
                         (mode_d == MODE_BODY);
    if (status != STAT_NONE) begin
      res.frame_cmd    = cmd_q;
      res.frame_length = len_q;
    end
    res.stream_control = stream_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q   <= MODE_IDLE;
      count_q  <= '0;
      sum_q    <= '0;
      len_q    <= '0;
      cmd_q    <= '0;
      baud_q   <= '0;
      stream_q <= '0;
    end else if (fire_i) begin
      mode_q   <= mode_d;
      count_q  <= count_d;
      sum_q    <= sum_d;
      len_q    <= len_d;
      cmd_q    <= cmd_d;
      baud_q   <= baud_d;
      stream_q <= stream_d;
    end
  end

  assign res_o = res;

endmodule

// ===== bench/sfp_result_checker.sv =====
`timescale 1ns / 100ps
// Result checker for the sync frame parser: watches the byte, result and register channels.
// Predicts one result per accepted byte and compares it field by field. Uses sfp_pkg.
module sfp_result_checker #(
  parameter int unsigned MAX_FRAME = sfp_pkg::SFP_MAX_FRAME
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           s_tvalid_i,
  input  logic                           s_tready_i,
  input  logic [7:0]                     s_tdata_i,
  input  logic                           m_tvalid_i,
  input  logic                           m_tready_i,
  input  logic [sfp_pkg::OUT_DATA_W-1:0] m_tdata_i,
  input  logic                           m_tuser_i,
  input  logic                           cfg_valid_i,
  input  logic                           cfg_ready_i,
  input  logic [sfp_pkg::CFG_IDX_W-1:0]  cfg_index_i,
  input  logic [sfp_pkg::CFG_DATA_W-1:0] cfg_data_i,
  output int                             errors_o,
  output int                             outstanding_o,
  output int                             checked_o
);
  import sfp_pkg::*;

  typedef enum logic [1:0] {
    MODE_IDLE,
    MODE_SYNC,
    MODE_BODY,
    MODE_PASS
  } frame_mode_e;

  // Own copy of the parser state and the registers.
  frame_mode_e mode;
  logic [8:0]  frame_pos;
  logic [7:0]  csum;
  logic [7:0]  held_len;
  logic [7:0]  frame_cmd;
  logic [31:0] baud_acc;
  logic [7:0]  stream_val;
  cfg_t        regs;

  result_t expected_results[$];
  result_t want;

  function automatic void open_frame();
    mode      = MODE_SYNC;
    frame_pos = 9'd1;
    csum      = 8'd0;
    baud_acc  = 32'd0;
  endfunction

  // Advance the parser by one byte and return the decode it must report.
  function automatic result_t decode_byte(input logic [7:0] b);
    result_t     r;
    int unsigned pos;
    int unsigned idx;
    r = '0;
    case (mode)
      MODE_PASS: begin
        if (b == SYNC_A) open_frame();
        else r.route_passthrough = 1'b1;
      end
      MODE_IDLE: begin
        if (b == SYNC_A) begin
          open_frame();
        end else if (b == PASS_KEY) begin
          mode = MODE_PASS;
          r.route_passthrough = 1'b1;
        end
      end
      MODE_SYNC: begin
        if (b == SYNC_B) begin
          mode      = MODE_BODY;
          frame_pos = 9'd2;
        end else if (b == SYNC_A) begin
          frame_pos = 9'd1;
        end else begin
          mode      = MODE_IDLE;
          frame_pos = 9'd0;
        end
      end
      default: begin
        if (frame_pos >= MAX_FRAME) begin
          r.frame_status = STAT_OVERFLOW;
          mode           = MODE_IDLE;
          frame_pos      = 9'd0;
        end else begin
          pos       = frame_pos;
          frame_pos = frame_pos + 9'd1;
          if (pos <= 4) begin
            if (pos == 3) held_len = b;
            else if (pos == 4) frame_cmd = b;
            csum = csum + b;
          end else if (pos < 5 + held_len) begin
            idx             = pos - 5;
            r.payload_valid = 1'b1;
            r.payload_byte  = b;
            r.payload_index = 8'(idx);
            if (idx < 4) baud_acc = baud_acc | (32'(b) << (8 * idx));
            csum = csum + b;
          end else begin
            mode      = MODE_IDLE;
            frame_pos = 9'd0;
            if (csum != b) begin
              r.frame_status = STAT_CSUM_ERR;
            end else begin
              r.frame_status = STAT_OK;
              if (frame_cmd == regs.cmd_stream_on) begin
                stream_val = (held_len >= 8'd1) ? baud_acc[7:0] : 8'd1;
              end else if (frame_cmd == regs.cmd_stream_off) begin
                stream_val = 8'd0;
              end else if (frame_cmd == regs.cmd_set_baud && held_len >= 8'd4 &&
                           regs.baud_hook_enabled) begin
                r.baud_valid = 1'b1;
                r.baud_value = baud_acc;
              end
              if (frame_cmd >= CLASS1_LO && frame_cmd <= CLASS1_HI)
                r.handler_class = HCLASS_HIGH;
              else if (frame_cmd >= CLASS2_LO && frame_cmd <= CLASS2_HI)
                r.handler_class = HCLASS_LOW;
              r.claimed = (r.handler_class != HCLASS_NONE);
            end
          end
        end
      end
    endcase
    if (mode == MODE_SYNC || mode == MODE_BODY) r.claimed = 1'b1;
    if (r.frame_status != STAT_NONE) begin
      r.frame_cmd    = frame_cmd;
      r.frame_length = held_len;
    end
    r.stream_control = stream_val;
    return r;
  endfunction

  task automatic check_field(input string name, input logic [31:0] exp_val,
                             input logic [31:0] act_val);
    if (act_val !== exp_val) begin
      $error("%s mismatch: expected 0x%0h, got 0x%0h", name, exp_val, act_val);
      errors_o++;
    end
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode       = MODE_IDLE;
      frame_pos  = 9'd0;
      csum       = 8'd0;
      held_len   = 8'd0;
      frame_cmd  = 8'd0;
      baud_acc   = 32'd0;
      stream_val = 8'd0;
      regs       = '0;
      expected_results.delete();
      errors_o   = 0;
      checked_o  = 0;
      outstanding_o <= 0;
    end else begin
      if (cfg_valid_i && cfg_ready_i) begin
        case (cfg_index_i)
          REG_STREAM_ON:  regs.cmd_stream_on     = cfg_data_i;
          REG_STREAM_OFF: regs.cmd_stream_off    = cfg_data_i;
          REG_SET_BAUD:   regs.cmd_set_baud      = cfg_data_i;
          REG_BAUD_HOOK:  regs.baud_hook_enabled = cfg_data_i[0];
          default: ;
        endcase
      end
      if (s_tvalid_i && s_tready_i) expected_results.push_back(decode_byte(s_tdata_i));
      if (m_tvalid_i && m_tready_i) begin
        if (expected_results.size() == 0) begin
          $error("result transfer arrived with no byte awaiting its result");
          errors_o++;
        end else begin
          want = expected_results.pop_front();
          check_field("route_passthrough", want.route_passthrough, m_tuser_i);
          check_field("claimed", want.claimed, m_tdata_i[0]);
          check_field("payload_valid", want.payload_valid, m_tdata_i[1]);
          check_field("payload_byte", want.payload_byte, m_tdata_i[9:2]);
          check_field("payload_index", want.payload_index, m_tdata_i[17:10]);
          check_field("frame_status", want.frame_status, m_tdata_i[19:18]);
          check_field("frame_cmd", want.frame_cmd, m_tdata_i[27:20]);
          check_field("frame_length", want.frame_length, m_tdata_i[35:28]);
          check_field("handler_class", want.handler_class, m_tdata_i[37:36]);
          check_field("stream_control", want.stream_control, m_tdata_i[45:38]);
          check_field("baud_valid", want.baud_valid, m_tdata_i[46]);
          check_field("baud_value", want.baud_value, m_tdata_i[78:47]);
          check_field("tdata padding", 32'd0, m_tdata_i[79]);
          checked_o++;
        end
      end
      outstanding_o <= expected_results.size();
    end
  end

endmodule

// ===== bench/sync_frame_parser_with_passthrough_test.sv =====
`timescale 1ns / 100ps
// Top of the sync frame parser bench: clock, reset, byte and register stimulus, verdict.
// Depends on sfp_pkg, the parser RTL and sfp_result_checker.
module sync_frame_parser_with_passthrough_test;
  import sfp_pkg::*;

  localparam int         TARGET_BYTES = 1350;
  localparam int         CYCLE_LIMIT  = 200000;
  localparam int         HOLD_CYCLES  = 300;
  localparam int         HOLD_AT      = 750;
  localparam int         CALM_FROM    = 900;
  localparam int         CALM_TO      = 1100;
  localparam logic [7:0] NO_SUCH_REG  = 8'hFC;

  logic                  clk_i = 1'b0;
  logic                  rst_ni = 1'b0;
  logic                  s_tvalid = 1'b0;
  logic                  s_tready;
  logic [7:0]            s_tdata = 8'd0;
  logic                  m_tvalid;
  logic                  m_tready = 1'b0;
  logic [OUT_DATA_W-1:0] m_tdata;
  logic                  m_tuser;
  logic                  cfg_valid = 1'b0;
  logic                  cfg_ready;
  logic [CFG_IDX_W-1:0]  cfg_index = '0;
  logic [CFG_DATA_W-1:0] cfg_data = '0;

  // calm: no idling on either side; hold_req: ask the receiver for one long hold-off
  logic calm = 1'b0;
  logic hold_req = 1'b0;

  int errors, outstanding, checked;
  int cycle_count = 0;
  int bytes_sent = 0;
  int frames_sent = 0;
  int settings_used = 0;
  int hold_left = 0;
  bit hold_done = 1'b0;

  // Current register contents, so that frames can aim at the configured commands.
  logic [7:0] on_cmd = 8'd0;
  logic [7:0] off_cmd = 8'd0;
  logic [7:0] baud_cmd = 8'd0;

  always begin
    #4 clk_i = 1'b1;
    #4 clk_i = 1'b0;
  end

  sync_frame_parser_with_passthrough dut (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .s_axis_tvalid_i (s_tvalid),
    .s_axis_tready_o (s_tready),
    .s_axis_tdata_i  (s_tdata),
    .m_axis_tvalid_o (m_tvalid),
    .m_axis_tready_i (m_tready),
    .m_axis_tdata_o  (m_tdata),
    .m_axis_tuser_o  (m_tuser),
    .cfg_valid_i     (cfg_valid),
    .cfg_ready_o     (cfg_ready),
    .cfg_index_i     (cfg_index),
    .cfg_data_i      (cfg_data)
  );

  sfp_result_checker u_checker (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_tvalid_i    (s_tvalid),
    .s_tready_i    (s_tready),
    .s_tdata_i     (s_tdata),
    .m_tvalid_i    (m_tvalid),
    .m_tready_i    (m_tready),
    .m_tdata_i     (m_tdata),
    .m_tuser_i     (m_tuser),
    .cfg_valid_i   (cfg_valid),
    .cfg_ready_i   (cfg_ready),
    .cfg_index_i   (cfg_index),
    .cfg_data_i    (cfg_data),
    .errors_o      (errors),
    .outstanding_o (outstanding),
    .checked_o     (checked)
  );

  // Guard against a hung handshake.
  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("Timeout after %0d cycles with %0d results outstanding", cycle_count, outstanding);
      $display("Test completed with failures");
      $finish;
    end
  end

  // Result receiver: random back-pressure, none while calm, and one long hold-off on
  // request. The hold-off is counted here so the sender keeps offering bytes meanwhile.
  always @(posedge clk_i) begin
    if (!rst_ni) begin
      m_tready <= 1'b0;
    end else if (hold_left > 0) begin
      m_tready <= 1'b0;
      hold_left--;
    end else if (hold_req && !hold_done) begin
      hold_done = 1'b1;
      hold_left = HOLD_CYCLES - 1;
      m_tready <= 1'b0;
    end else begin
      m_tready <= calm || ($urandom_range(99) >= 30);
    end
  end

  // Offer one byte, idling first now and then, and hold it until the transfer.
  task automatic push_byte(input logic [7:0] b);
    if (!calm && $urandom_range(99) < 30) begin
      s_tvalid <= 1'b0;
      repeat ($urandom_range(1, 2)) @(posedge clk_i);
    end
    s_tvalid <= 1'b1;
    s_tdata  <= b;
    @(posedge clk_i);
    while (!s_tready) @(posedge clk_i);
    bytes_sent++;
  endtask

  // Stop sending and wait until every byte has had its result, plus the pipeline depth.
  task automatic drain();
    s_tvalid <= 1'b0;
    @(posedge clk_i);
    while (outstanding != 0) @(posedge clk_i);
    repeat (4) @(posedge clk_i);
  endtask

  // Raise the write and hold it until taken; the caller drops cfg_valid after the last one.
  task automatic write_reg(input logic [7:0] idx, input logic [7:0] val);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    @(posedge clk_i);
    while (!cfg_ready) @(posedge clk_i);
  endtask

  task automatic load_settings(input logic [7:0] on_val, input logic [7:0] off_val,
                               input logic [7:0] baud_val, input logic [7:0] hook_val,
                               input bit poke_unused);
    drain();
    write_reg(REG_STREAM_ON, on_val);
    write_reg(REG_STREAM_OFF, off_val);
    write_reg(REG_SET_BAUD, baud_val);
    write_reg(REG_BAUD_HOOK, hook_val);
    // An unused index must leave every register alone.
    if (poke_unused) write_reg(NO_SUCH_REG, 8'($urandom));
    cfg_valid <= 1'b0;
    on_cmd   = on_val;
    off_cmd  = off_val;
    baud_cmd = baud_val;
    settings_used++;
  endtask

  // Send a complete frame with a random payload; optionally spoil the checksum.
  task automatic send_frame(input logic [7:0] addr, input int len, input logic [7:0] cmd,
                            input bit corrupt_sum);
    logic [7:0] sum;
    logic [7:0] pl;
    sum = addr + 8'(len) + cmd;
    push_byte(SYNC_A);
    push_byte(SYNC_B);
    push_byte(addr);
    push_byte(8'(len));
    push_byte(cmd);
    for (int i = 0; i < len; i++) begin
      pl  = 8'($urandom);
      sum = sum + pl;
      push_byte(pl);
    end
    push_byte(corrupt_sum ? sum ^ 8'($urandom_range(1, 255)) : sum);
    frames_sent++;
  endtask

  // Favour the configured commands and the edges of the handler ranges.
  function automatic logic [7:0] pick_cmd();
    case ($urandom_range(7))
      0:       return on_cmd;
      1:       return off_cmd;
      2, 3:    return baud_cmd;
      4:       return 8'($urandom_range(CLASS1_LO, CLASS1_HI));
      5:       return 8'($urandom_range(CLASS2_LO, CLASS2_HI));
      6: begin
        case ($urandom_range(3))
          0:       return CLASS2_HI + 8'd1;
          1:       return CLASS2_LO - 8'd1;
          2:       return CLASS1_HI + 8'd1;
          default: return CLASS2_HI;
        endcase
      end
      default: return 8'($urandom);
    endcase
  endfunction

  initial begin
    int          kind;
    int          len;
    int          phase;
    int          next_switch;
    logic [7:0]  b;
    phase       = 0;
    next_switch = 650;

    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed part, reset register values (every command code zero, baud hook off).
    // Enter passthrough on 'H', route a few bytes, leave it with the sync byte and
    // send a stream-on frame with an empty payload.
    push_byte(PASS_KEY);
    push_byte(8'h00);
    push_byte(8'hFF);
    push_byte(PASS_KEY);
    send_frame(8'h12, 0, 8'h00, 1'b0);
    // Repeated first sync byte restarts the wait; 'H' in place of the second one
    // must drop back to idle rather than into passthrough.
    push_byte(SYNC_A);
    push_byte(SYNC_A);
    push_byte(PASS_KEY);
    push_byte(8'h01);
    // Checksum error, then a good frame at the top of the first handler range.
    send_frame(8'hFF, 1, CLASS2_LO, 1'b1);
    send_frame(8'h00, 2, CLASS1_HI, 1'b0);

    // Distinct commands, each in a handler range, baud hook attached.
    load_settings(8'h41, 8'h22, 8'h60, 8'h01, 1'b0);
    // Longest frame that fits, then one byte too long: the checksum byte overflows.
    send_frame(8'h5A, 254, on_cmd, 1'b0);
    send_frame(8'hA5, 255, baud_cmd, 1'b0);

    // Random part: mostly well-formed frames, the rest passthrough runs, noise
    // and broken frames. Switch settings between chunks once the block is drained.
    while (bytes_sent < TARGET_BYTES) begin
      if (bytes_sent >= next_switch && phase < 4) begin
        case (phase)
          0:       load_settings(8'hFF, 8'h00, 8'hFF, 8'hFE, 1'b0);
          1:       load_settings(CLASS2_HI, CLASS2_HI, CLASS2_HI, 8'h01, 1'b0);
          2:       load_settings(8'($urandom), 8'($urandom), 8'($urandom), 8'($urandom), 1'b1);
          default: load_settings(8'h00, 8'hFF, 8'h7F, 8'hFF, 1'b0);
        endcase
        phase++;
        next_switch += 200;
      end
      if (!calm && bytes_sent >= CALM_FROM && bytes_sent < CALM_TO) calm <= 1'b1;
      else if (calm && bytes_sent >= CALM_TO) calm <= 1'b0;
      if (!hold_req && bytes_sent >= HOLD_AT) hold_req <= 1'b1;

      kind = $urandom_range(99);
      if (kind < 70) begin
        len = ($urandom_range(59) == 0) ? $urandom_range(200, 255) : $urandom_range(0, 9);
        send_frame(8'($urandom), len, pick_cmd(), $urandom_range(99) < 15);
      end else if (kind < 80) begin
        push_byte(PASS_KEY);
        repeat ($urandom_range(1, 6)) push_byte(8'($urandom));
      end else if (kind < 90) begin
        repeat ($urandom_range(1, 5)) push_byte(8'($urandom));
      end else begin
        // Broken sequence: a lone sync byte, or a header cut short so that the
        // next bytes are taken as its body.
        push_byte(SYNC_A);
        if ($urandom_range(1) == 0) begin
          b = 8'($urandom);
          push_byte(b);
        end else begin
          push_byte(SYNC_B);
          push_byte(8'($urandom));
          push_byte(8'($urandom_range(0, 6)));
          push_byte(pick_cmd());
        end
      end
    end

    drain();
    $display("Covered %0d bytes with %0d whole frames; %0d results compared.",
             bytes_sent, frames_sent, checked);
    $display("Register settings used: %0d, extremes and overlapping command codes among them.",
             settings_used);
    if (errors == 0 && outstanding == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule
